// ===== hw/rtl/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// cond must never be true outside reset
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SEV_W = 16;
  localparam int TAG_W = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SERVE  = 2'd1,
    MODE_CLEAR  = 2'd2
  } spq_mode_e;

  typedef enum logic [1:0] {
    ST_SERVED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic [SEV_W-1:0] sev;
    logic [TAG_W-1:0] tag;
  } spq_entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       ins;
    logic       srv;
    spq_entry_t ent;
  } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell #(
  parameter int Capacity = spq_pkg::CAPACITY_DEF,
  parameter int CellIdx  = 0
) (
  input  logic                                clk_i,
  input  spq_pkg::spq_ctrl_t                  ctrl_i,
  input  logic [$clog2(Capacity+1)-1:0]       count_i,
  input  logic                                left_beat_i,
  input  spq_pkg::spq_entry_t                 left_entry_i,
  input  spq_pkg::spq_entry_t                 right_entry_i,
  output logic                                beat_o,
  output spq_pkg::spq_entry_t                 entry_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] IdxC = CntW'(CellIdx);

  spq_entry_t entry_q, entry_d;
  logic       occupied;

  // new word beats this cell if the cell is empty or the word outranks it; equal severity keeps the older entry ahead
  assign occupied = IdxC < count_i;
  assign beat_o   = !occupied || (ctrl_i.ent.sev > entry_q.sev);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && beat_o) begin
      entry_d = left_beat_i ? left_entry_i : ctrl_i.ent;
    end else if (ctrl_i.srv) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/severity_priority_queue_core.sv =====
// channel | valid       | stall       | word
// --------+-------------+-------------+-----------------------------------------------------
// in      | in_valid_i  | in_stall_o  | in_mode_i, in_severity_i, in_tag_i
// out     | out_valid_o | out_stall_i | out_served_tag_o, out_served_severity_o, out_status_o
//
// One word per cycle while in_stall_o is low: the sorted cell chain shifts right on insert
// and left on serve; a result is registered and appears at the output in the next cycle.
// Reset (async, rst_ni low) empties the queue; cell contents are not reset.
// in_stall_o rises only when a word that gives a result meets a held result.
// Clears and inserts into a non-full queue keep flowing while the output is stalled.
module severity_priority_queue_core #(
  parameter int Capacity = spq_pkg::CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_mode_i,
  input  logic [spq_pkg::SEV_W-1:0] in_severity_i,
  input  logic [spq_pkg::TAG_W-1:0] in_tag_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [spq_pkg::TAG_W-1:0] out_served_tag_o,
  output logic [spq_pkg::SEV_W-1:0] out_served_severity_o,
  output logic [1:0]                out_status_o
);
  import spq_pkg::*;
  `include "assert_macros.svh"

  localparam int CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [SEV_W-1:0]  out_sev_q, out_sev_d;
  spq_status_e       out_status_q, out_status_d;

  logic       full, empty, needs_out, accept;
  spq_ctrl_t  ctrl;

  spq_entry_t entry      [Capacity];
  logic       beat       [Capacity];
  logic       left_beat  [Capacity];
  spq_entry_t left_ent   [Capacity];
  spq_entry_t right_ent  [Capacity];

  assign full  = count_q == CntW'(Capacity);
  assign empty = count_q == '0;

  always_comb begin
    case (in_mode_i)
      MODE_SERVE:  needs_out = 1'b1;
      MODE_INSERT: needs_out = full;
      default:     needs_out = 1'b0;
    endcase
  end

  assign in_stall_o = out_valid_q && out_stall_i && needs_out;
  assign accept     = in_valid_i && !in_stall_o;

  assign ctrl.ins     = accept && (in_mode_i == MODE_INSERT) && !full;
  assign ctrl.srv     = accept && (in_mode_i == MODE_SERVE) && !empty;
  assign ctrl.ent.sev = in_severity_i;
  assign ctrl.ent.tag = in_tag_i;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_beat[i] = 1'b0;
      assign left_ent[i]  = ctrl.ent;
    end else begin : g_body
      assign left_beat[i] = beat[i-1];
      assign left_ent[i]  = entry[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign right_ent[i] = entry[i];
    end else begin : g_mid
      assign right_ent[i] = entry[i+1];
    end

    spq_cell #(
      .Capacity (Capacity),
      .CellIdx  (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_beat_i   (left_beat[i]),
      .left_entry_i  (left_ent[i]),
      .right_entry_i (right_ent[i]),
      .beat_o        (beat[i]),
      .entry_o       (entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      case (in_mode_i)
        MODE_INSERT: if (!full) begin
          count_d = count_q + 1'b1;
        end
        MODE_SERVE: if (!empty) begin
          count_d = count_q - 1'b1;
        end
        MODE_CLEAR:  count_d = '0;
        default:     count_d = count_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_tag_d    = out_tag_q;
    out_sev_d    = out_sev_q;
    out_status_d = out_status_q;
    if (accept && needs_out) begin
      out_valid_d = 1'b1;
      if (in_mode_i == MODE_INSERT) begin
        out_tag_d    = '0;
        out_sev_d    = '0;
        out_status_d = ST_FULL;
      end else if (empty) begin
        out_tag_d    = '0;
        out_sev_d    = '0;
        out_status_d = ST_EMPTY;
      end else begin
        out_tag_d    = entry[0].tag;
        out_sev_d    = entry[0].sev;
        out_status_d = ST_SERVED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tag_q    <= out_tag_d;
    out_sev_q    <= out_sev_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o           = out_valid_q;
  assign out_served_tag_o      = out_tag_q;
  assign out_served_severity_o = out_sev_q;
  assign out_status_o          = out_status_q;

  `SPQ_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Capacity))
  `SPQ_ASSERT(a_stall_held, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  `SPQ_ASSERT(a_empty_serve, clk_i, rst_ni,
    (accept && in_mode_i == MODE_SERVE && empty) |=> (out_valid_q && out_status_q == ST_EMPTY))
  `SPQ_ASSERT(a_insert_grows, clk_i, rst_ni,
    ctrl.ins |=> (count_q == $past(count_q) + 1'b1))

endmodule
